// ----- sv/generational_id_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Generational id allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_ID_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_ID_ALLOCATOR_MACROS_SVH

// Property checked only while reset is released.
`define GIA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must be low in the cycle after reset is applied.
`define GIA_ASSERT_RST_LOW(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> !sig) else $error(msg);

`endif

// ----- sv/gia_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational id allocator package
// Sizes, request and status codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package gia_pkg;

    localparam int SLOTS     = 1024;
    localparam int GEN_BITS  = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ID_W      = 11;
    localparam int RES_GEN_W = 16;
    localparam int POOL_W    = 8;
    localparam int LIMIT_W   = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 40;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_NEXT  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_PUT
    } t_state;

    typedef struct packed {
        logic                live;
        logic [GEN_BITS-1:0] gen;
        logic [SLOT_W-1:0]   link;
    } t_slot_word;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [SLOT_W-1:0] addr;
        t_slot_word        wdata;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_W-1:0]      id;
        logic [RES_GEN_W-1:0] gen;
        logic [POOL_W-1:0]    pool;
    } t_result;

endpackage

// ----- sv/generational_id_allocator.sv -----
// ----------------------------------------------------------------------------
// Generational id allocator
// Allocates, frees and scans generational object ids from a slot pool.
// ----------------------------------------------------------------------------
// One item is handled at a time through a single-port slot memory with a
// registered read. Allocate from a fresh slot writes the slot without a
// read; a request rejected without a memory read (unknown type, zero or
// out-of-range free, pool full) or a scan start past the last fresh slot
// goes straight to its result. Allocate from the free list and free make one
// memory read, then a write-back (none when the freed id turns out not to be
// live); next-live makes one memory read per slot examined. The result sits
// in an output register, so a finished item waits there while the next one
// is accepted. Live bits are only ever read below the fresh count, so no
// clearing pass follows reset.
module generational_id_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] req_type, [12:2] object_id, [15:13] zero
    input  logic [gia_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [12:2] result_id, [28:13] result_gen, [36:29] result_pool,
    // [39:37] zero
    output logic [gia_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [gia_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gia_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import gia_pkg::*;

    logic [POOL_W-1:0]  r_pool_id;
    logic [LIMIT_W-1:0] r_slot_limit;
    logic               r_out_valid;
    t_result            r_out;

    t_mem_req   mem_req;
    t_slot_word mem_rd;
    logic       res_valid;
    t_result    res;
    logic       res_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_id    <= '0;
            r_slot_limit <= LIMIT_W'(SLOTS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_ID:    r_pool_id    <= i_cfg_wdata[POOL_W-1:0];
                CFG_SLOT_LIMIT: r_slot_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    gia_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_req        (s_axis_tdata[1:0]),
        .i_oid        (s_axis_tdata[12:2]),
        .i_pool_id    (r_pool_id),
        .i_slot_limit (r_slot_limit),
        .o_mem        (mem_req),
        .i_rd         (mem_rd),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    gia_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd  (mem_rd)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.pool, r_out.gen, r_out.id, r_out.status};

endmodule

// ----- sv/gia_store.sv -----
// ----------------------------------------------------------------------------
// Slot store
// Single-port slot memory holding live bit, generation and free-list link.
// ----------------------------------------------------------------------------
module gia_store (
    input  logic              i_clk,
    input  gia_pkg::t_mem_req i_req,
    output gia_pkg::t_slot_word o_rd
);
    import gia_pkg::*;

    t_slot_word r_mem [SLOTS];
    t_slot_word r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.addr];
        end
    end

    assign o_rd = r_rd;

endmodule

// ----- sv/gia_seq.sv -----
// ----------------------------------------------------------------------------
// Allocator sequencer
// Decodes requests, drives the slot store and builds one result per item.
// ----------------------------------------------------------------------------
module gia_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req,
    input  logic [gia_pkg::ID_W-1:0]      i_oid,
    input  logic [gia_pkg::POOL_W-1:0]    i_pool_id,
    input  logic [gia_pkg::LIMIT_W-1:0]   i_slot_limit,
    output gia_pkg::t_mem_req             o_mem,
    input  gia_pkg::t_slot_word           i_rd,
    output logic                          o_res_valid,
    output gia_pkg::t_result              o_res,
    input  logic                          i_res_take
);
    import gia_pkg::*;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_is_free, n_is_free;
    logic [SLOT_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]  r_fresh, n_fresh;
    t_result           r_res, n_res;

    logic                accept;
    logic [LIMIT_W-1:0]  limit;
    logic                bad_free;
    logic                next_none;
    logic [CNT_W-1:0]    scan_next;
    logic                scan_end;
    logic [GEN_BITS-1:0] gen_inc;
    logic [ID_W-1:0]     slot_id;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign limit     = (i_slot_limit > LIMIT_W'(SLOTS)) ? LIMIT_W'(SLOTS) : i_slot_limit;
    assign bad_free  = (i_oid == '0) || (i_oid > ID_W'(r_fresh));
    assign next_none = (i_oid >= ID_W'(r_fresh));
    assign scan_next = CNT_W'(r_slot) + CNT_W'(1);
    assign scan_end  = (scan_next >= r_fresh);
    assign gen_inc   = i_rd.gen + GEN_BITS'(1);
    assign slot_id   = ID_W'(r_slot) + ID_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req)
                        REQ_ALLOC: n_state = (r_free_cnt != '0) ? S_READ : S_PUT;
                        REQ_FREE:  n_state = bad_free ? S_PUT : S_READ;
                        REQ_NEXT:  n_state = next_none ? S_PUT : S_SCAN;
                        default:   n_state = S_PUT;
                    endcase
                end
            end
            S_READ: n_state = S_PUT;
            S_SCAN: begin
                if (i_rd.live || scan_end) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_mem       = '0;
        n_slot      = r_slot;
        n_is_free   = r_is_free;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_fresh     = r_fresh;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '{status: ST_BAD, default: '0};
                    case (i_req)
                        REQ_ALLOC: begin
                            if (r_free_cnt != '0) begin
                                // pop the list head; link comes back with the read
                                o_mem.re  = 1'b1;
                                o_mem.addr = r_free_head;
                                n_slot    = r_free_head;
                                n_is_free = 1'b0;
                            end else if (r_fresh < CNT_W'(limit)) begin
                                o_mem.we         = 1'b1;
                                o_mem.addr       = r_fresh[SLOT_W-1:0];
                                o_mem.wdata.live = 1'b1;
                                o_mem.wdata.gen  = GEN_BITS'(1);
                                n_fresh          = r_fresh + CNT_W'(1);
                                n_res.status     = ST_OK;
                                n_res.id         = ID_W'(r_fresh) + ID_W'(1);
                                n_res.gen        = RES_GEN_W'(1);
                                n_res.pool       = i_pool_id;
                            end else begin
                                n_res.status = ST_NONE;
                            end
                        end
                        REQ_FREE: begin
                            if (!bad_free) begin
                                o_mem.re   = 1'b1;
                                o_mem.addr = SLOT_W'(i_oid - ID_W'(1));
                                n_slot     = SLOT_W'(i_oid - ID_W'(1));
                                n_is_free  = 1'b1;
                            end
                        end
                        REQ_NEXT: begin
                            if (next_none) begin
                                n_res.status = ST_NONE;
                            end else begin
                                o_mem.re   = 1'b1;
                                o_mem.addr = SLOT_W'(i_oid);
                                n_slot     = SLOT_W'(i_oid);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (r_is_free) begin
                    if (i_rd.live) begin
                        // advance generation, push slot onto the free list
                        o_mem.we         = 1'b1;
                        o_mem.addr       = r_slot;
                        o_mem.wdata.live = 1'b0;
                        o_mem.wdata.gen  = gen_inc;
                        o_mem.wdata.link = r_free_head;
                        n_free_head      = r_slot;
                        n_free_cnt       = r_free_cnt + CNT_W'(1);
                        n_res            = '{ST_OK, slot_id, RES_GEN_W'(gen_inc), i_pool_id};
                    end
                end else begin
                    o_mem.we         = 1'b1;
                    o_mem.addr       = r_slot;
                    o_mem.wdata.live = 1'b1;
                    o_mem.wdata.gen  = i_rd.gen;
                    o_mem.wdata.link = i_rd.link;
                    n_free_head      = i_rd.link;
                    n_free_cnt       = r_free_cnt - CNT_W'(1);
                    n_res            = '{ST_OK, slot_id, RES_GEN_W'(i_rd.gen), i_pool_id};
                end
            end
            S_SCAN: begin
                if (i_rd.live) begin
                    n_res = '{ST_OK, slot_id, RES_GEN_W'(i_rd.gen), i_pool_id};
                end else if (scan_end) begin
                    n_res = '{status: ST_NONE, default: '0};
                end else begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = scan_next[SLOT_W-1:0];
                    n_slot     = scan_next[SLOT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_free_cnt  <= '0;
            r_fresh     <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_fresh     <= n_fresh;
        end
        r_slot    <= n_slot;
        r_is_free <= n_is_free;
        r_res     <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_PUT);
    assign o_res       = r_res;

endmodule

// ----- sv/gia_checker.sv -----
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the allocator ports for handshake and result-format slips.
// ----------------------------------------------------------------------------
`include "generational_id_allocator_macros.svh"

module gia_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [gia_pkg::IN_W-1:0]      s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gia_pkg::OUT_W-1:0]     m_axis_tdata,
    input logic                          i_cfg_we,
    input logic [gia_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [gia_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import gia_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, i_cfg_we, i_cfg_idx, i_cfg_wdata};

    `GIA_ASSERT_RST_LOW(a_rst_out_idle, i_clk, i_rst_n, m_axis_tvalid, "output valid after reset")

    `GIA_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")

    `GIA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in work")

    `GIA_ASSERT(a_ok_has_id, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ST_OK) |-> (m_axis_tdata[12:2] != '0), "ok result without id")

    `GIA_ASSERT(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[OUT_W-1:2] == '0) && (m_axis_tdata[1:0] != 2'd3), "failed result carries data")

endmodule

bind generational_id_allocator gia_checker u_gia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_wdata   (i_cfg_wdata)
);

// ----- verif/tb_generational_id_allocator.sv -----
// ----------------------------------------------------------------------------
// Generational id allocator testbench
// Drives allocate, free, next-live and malformed requests through the
// stream ports under several pool and limit settings, with random gaps and
// stalls on both sides. A shadow copy of the slot pool (free list, fresh
// counter, generations, live bits) predicts each reply, and every reply is
// checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_generational_id_allocator;

    import gia_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int ID_LO         = 2;
    localparam int GEN_LO        = ID_LO + ID_W;
    localparam int POOL_LO       = GEN_LO + RES_GEN_W;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int PHASE_ITEMS   = 180;
    localparam int RECYCLE_ROUNDS = 32;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    // shadow of the slot pool
    logic [SLOT_W-1:0]   next_free [SLOTS];
    logic [GEN_BITS-1:0] gen_of    [SLOTS];
    bit                  is_live   [SLOTS];
    int                  free_top   = 0;
    int                  free_depth = 0;
    int                  fresh_used = 0;
    logic [POOL_W-1:0]   cur_pool   = '0;
    logic [LIMIT_W-1:0]  cur_limit  = LIMIT_W'(SLOTS);

    t_result pending_replies[$];
    int      mismatch_count  = 0;
    int      send_idle_pct   = 0;
    int      recv_stall_pct  = 0;
    int      holdoff_request = 0;

    generational_id_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #240_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int limit_cap();
        return (cur_limit > SLOTS) ? SLOTS : int'(cur_limit);
    endfunction

    // Work out the allocator's reply to one accepted item and update the shadow.
    function automatic void predict_reply(input logic [1:0] req, input logic [ID_W-1:0] oid);
        t_result r;
        int      slot;
        bit      found;
        r     = '0;
        found = 1'b0;
        slot  = 0;
        case (req)
            REQ_ALLOC: begin
                if (free_depth != 0) begin
                    slot       = free_top;
                    free_top   = next_free[slot];
                    free_depth = free_depth - 1;
                    found      = 1'b1;
                end else if (fresh_used < limit_cap()) begin
                    slot         = fresh_used;
                    fresh_used   = fresh_used + 1;
                    gen_of[slot] = GEN_BITS'(1);
                    found        = 1'b1;
                end
                if (found) begin
                    is_live[slot] = 1'b1;
                    r.status      = ST_OK;
                    r.id          = ID_W'(slot + 1);
                    r.gen         = gen_of[slot];
                    r.pool        = cur_pool;
                end else begin
                    r.status = ST_NONE;
                end
            end
            REQ_FREE: begin
                if (oid == 0 || oid > fresh_used || !is_live[oid - 1]) begin
                    r.status = ST_BAD;
                end else begin
                    slot            = oid - 1;
                    gen_of[slot]    = gen_of[slot] + 1'b1;
                    is_live[slot]   = 1'b0;
                    next_free[slot] = SLOT_W'(free_top);
                    free_top        = slot;
                    free_depth      = free_depth + 1;
                    r.status        = ST_OK;
                    r.id            = oid;
                    r.gen           = gen_of[slot];
                    r.pool          = cur_pool;
                end
            end
            REQ_NEXT: begin
                r.status = ST_NONE;
                for (int s = oid; s < fresh_used; s++) begin
                    if (is_live[s] && !found) begin
                        found    = 1'b1;
                        r.status = ST_OK;
                        r.id     = ID_W'(s + 1);
                        r.gen    = gen_of[s];
                        r.pool   = cur_pool;
                    end
                end
            end
            default: begin
                r.status = ST_BAD;
            end
        endcase
        pending_replies.push_back(r);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 100)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_reply(input logic [OUT_W-1:0] data);
        t_result want;
        if (pending_replies.size() == 0) begin
            flag_mismatch("unexpected reply", data, 0);
            return;
        end
        want = pending_replies.pop_front();
        if (data[1:0] !== want.status)
            flag_mismatch("status", data[1:0], want.status);
        if (data[ID_LO +: ID_W] !== want.id)
            flag_mismatch("result_id", data[ID_LO +: ID_W], want.id);
        if (data[GEN_LO +: RES_GEN_W] !== want.gen)
            flag_mismatch("result_gen", data[GEN_LO +: RES_GEN_W], want.gen);
        if (data[POOL_LO +: POOL_W] !== want.pool)
            flag_mismatch("result_pool", data[POOL_LO +: POOL_W], want.pool);
    endtask

    // Sample mid-cycle: the handshake seen here completes at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            check_reply(m_axis_tdata);
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_request != 0) begin
                stall_left      = holdoff_request;
                holdoff_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one item and hold it until accepted; valid stays high for a
    // following item unless a gap is drawn.
    task automatic send_request(input logic [1:0] req, input logic [ID_W-1:0] oid);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, oid, req};
        // check ready mid-cycle, ahead of the edge that takes the item
        do @(negedge i_clk); while (s_axis_tready !== 1'b1);
        predict_reply(req, oid);
        @(posedge i_clk);
    endtask

    task automatic wait_replies_done();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            flag_mismatch("missing replies", pending_replies.size(), 0);
            pending_replies.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [POOL_W-1:0] pool, input logic [LIMIT_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_POOL_ID;
        i_cfg_wdata <= CFG_W'(pool);
        @(posedge i_clk);
        cur_pool     = pool;
        i_cfg_idx   <= CFG_SLOT_LIMIT;
        i_cfg_wdata <= CFG_W'(limit);
        @(posedge i_clk);
        cur_limit    = limit;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [ID_W-1:0] pick_live_id();
        int s;
        if (fresh_used == 0)
            return '0;
        repeat (8) begin
            s = $urandom_range(fresh_used - 1);
            if (is_live[s])
                return ID_W'(s + 1);
        end
        return ID_W'($urandom_range(fresh_used));
    endfunction

    // Mostly well-formed traffic on live ids, plus some malformed items.
    task automatic pick_request(output logic [1:0] req, output logic [ID_W-1:0] oid);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35) begin
            req = REQ_ALLOC;
            oid = ID_W'($urandom_range(2047));
        end else if (roll < 65) begin
            req = REQ_FREE;
            oid = pick_live_id();
        end else if (roll < 85) begin
            req = REQ_NEXT;
            oid = ID_W'($urandom_range(fresh_used));
        end else begin
            req = 2'($urandom_range(3));
            oid = ID_W'($urandom_range(2047));
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(8'hFF, 11'd4);
        send_request(REQ_NEXT, 0);            // nothing live yet
        send_request(REQ_FREE, 0);            // id zero
        send_request(REQ_FREE, 1);            // above fresh count
        send_request(REQ_UNKNOWN, 11'h7FF);
        repeat (4) send_request(REQ_ALLOC, 0);
        send_request(REQ_ALLOC, 0);           // pool full
        send_request(REQ_NEXT, 0);
        send_request(REQ_NEXT, 4);            // scan start at fresh count
        send_request(REQ_NEXT, 11'h7FF);
        send_request(REQ_FREE, 2);
        send_request(REQ_FREE, 2);            // no longer live
        send_request(REQ_FREE, 5);
        send_request(REQ_NEXT, 1);            // skip the freed slot
        send_request(REQ_ALLOC, 0);           // reuse keeps the bumped generation
        send_request(REQ_FREE, 4);
        send_request(REQ_FREE, 1);
        send_request(REQ_ALLOC, 0);           // last freed comes back first
        send_request(REQ_ALLOC, 0);
        wait_replies_done();
    endtask

    // Slots already on the free list stay usable above a lowered limit.
    task automatic test_limit_lowered();
        send_request(REQ_FREE, 3);
        send_request(REQ_FREE, 4);
        wait_replies_done();
        set_config(8'h00, 11'd1);
        repeat (3) send_request(REQ_ALLOC, 0);
        wait_replies_done();
    endtask

    // Cycle one slot through free and reuse so its generation keeps advancing.
    task automatic test_slot_recycle();
        logic [ID_W-1:0] victim;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        victim = '0;
        for (int s = fresh_used - 1; s >= 0; s--) begin
            if (is_live[s])
                victim = ID_W'(s + 1);
        end
        repeat (RECYCLE_ROUNDS) begin
            send_request(REQ_FREE, victim);
            send_request(REQ_ALLOC, 0);
        end
        wait_replies_done();
    endtask

    task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct,
                                    input logic [POOL_W-1:0] pool,
                                    input logic [LIMIT_W-1:0] limit);
        logic [1:0]      req;
        logic [ID_W-1:0] oid;
        set_config(pool, limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) begin
            pick_request(req, oid);
            send_request(req, oid);
        end
        wait_replies_done();
    endtask

    // Fill the whole pool while the receiver holds off, so the input backs up.
    task automatic test_fill_under_backpressure();
        set_config(8'hFF, LIMIT_W'(SLOTS));
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        holdoff_request = 400;
        while (free_depth != 0 || fresh_used < limit_cap())
            send_request(REQ_ALLOC, ID_W'($urandom_range(2047)));
        send_request(REQ_ALLOC, 0);           // pool full at the largest limit
        send_request(REQ_NEXT, 0);
        send_request(REQ_NEXT, SLOTS - 1);
        send_request(REQ_NEXT, SLOTS);
        send_request(REQ_FREE, SLOTS);
        send_request(REQ_FREE, 11'h7FF);
        send_request(REQ_NEXT, 0);
        wait_replies_done();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_POOL_ID;
        i_cfg_wdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_limit_lowered();
        test_slot_recycle();
        run_random_phase(PHASE_ITEMS, 0, 0, POOL_W'($urandom_range(255)), 11'd16);
        run_random_phase(PHASE_ITEMS, 54, 0, POOL_W'($urandom_range(255)), 11'd1);
        run_random_phase(PHASE_ITEMS, 0, 54, POOL_W'($urandom_range(255)), 11'd64);
        test_fill_under_backpressure();
        run_random_phase(PHASE_ITEMS, 37, 37, 8'h00, LIMIT_W'(SLOTS));

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/gia_pkg.sv
sv/gia_store.sv
sv/gia_seq.sv
sv/generational_id_allocator.sv
sv/gia_checker.sv
verif/tb_generational_id_allocator.sv
